FILE: rtl/pcp_pkg.sv
package pcp_pkg;

    // Field widths fixed by the item formats.
    localparam int PAD_W     = 8;
    localparam int VAL_W     = 12;
    localparam int TIME_W    = 16;
    localparam int CFG_W     = 32;
    localparam int HW_W      = 4;
    localparam int CFG_IDX_W = 3;
    localparam int ENTRY_W   = PAD_W + VAL_W;
    // Quotient bits of the centroid division (pad < 256 in Q16.16 plus rounding).
    localparam int Q_W       = 24;
    localparam int Q_CNT_W   = 5;

    localparam logic signed [CFG_W-1:0] X_SLOPE_RST  = 32'sd65536;
    localparam logic signed [CFG_W-1:0] X_OFFSET_RST = 32'sd0;
    localparam logic signed [CFG_W-1:0] Y_SLOPE_RST  = 32'sd65536;
    localparam logic signed [CFG_W-1:0] Y_OFFSET_RST = 32'sd0;
    localparam logic [HW_W-1:0]         HALF_WIN_RST = 4'd7;
    localparam logic [Q_W:0]            HALF_Q16     = 25'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_SLOPE  = 3'd0,
        CFG_X_OFFSET = 3'd1,
        CFG_Y_SLOPE  = 3'd2,
        CFG_Y_OFFSET = 3'd3,
        CFG_HALF_WIN = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MAX,
        ST_SUM,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_run;
        logic pass_sum;
        logic div_init;
        logic div_step;
        logic mult;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_acc;
        logic scan_done;
        logic div_done;
        logic out_free;
    } stat_t;

    // Saturate a signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = 64'sh0000_0000_7FFF_FFFF;
        lo_lim = -64'sh0000_0000_8000_0000;
        if (v > hi_lim)
            return 32'sh7FFF_FFFF;
        else if (v < lo_lim)
            return -32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: rtl/pcp_in_if.sv
interface pcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pad;
    logic [11:0] sample_value;
    logic [15:0] drift_time;
    logic       last;

    modport source (output valid, output pad, output sample_value, output drift_time,
                    output last, input ready);
    modport sink (input valid, input pad, input sample_value, input drift_time,
                  input last, output ready);
endinterface

FILE: rtl/pcp_out_if.sv
interface pcp_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         max_pad;
    logic [11:0]        max_charge;
    logic signed [31:0] x_position;
    logic               x_valid;
    logic signed [31:0] y_position;

    modport source (output valid, output max_pad, output max_charge, output x_position,
                    output x_valid, output y_position, input ready);
    modport sink (input valid, input max_pad, input max_charge, input x_position,
                  input x_valid, input y_position, output ready);
endinterface

FILE: rtl/pad_centroid_position.sv
// Pad centroid position.
// sample_in carries one event's pad samples, one item per cycle while loading;
// the item with last set closes the event and brings its drift time.
// result_out carries one item per event: maximum pad and charge, the windowed
// center-of-gravity x position and the scaled drift time y, both Q16.16.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce this. After the last item,
// the block reads the sample store twice (maximum search, then window sums),
// one entry per cycle through the single read port. The divider, the
// multipliers and the output stage then follow in that order, and the first
// sample of the next event can be taken once the result has entered the
// output register.
// The next event can be loaded while a result waits; its passes and division
// run at once, but its result enters the output register only once the
// previous result has been taken, and the output register holds while the
// receiver stalls. Input is not accepted while an event is being processed.
// Reset returns configuration to defaults and clears the sample count.
module pad_centroid_position #(
    parameter int MAX_SAMPLES = 512,
    parameter int PAD_COUNT   = 224
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pcp_in_if.sink                        sample_in,
    pcp_out_if.source                     result_out,
    input  logic                          cfg_we,
    input  logic [pcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcp_pkg::CFG_W-1:0]     cfg_data
);
    import pcp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pcp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    pcp_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .PAD_COUNT   (PAD_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (sample_in.valid),
        .in_ready       (sample_in.ready),
        .in_pad         (sample_in.pad),
        .in_value       (sample_in.sample_value),
        .in_time        (sample_in.drift_time),
        .in_last        (sample_in.last),
        .out_valid      (result_out.valid),
        .out_ready      (result_out.ready),
        .out_max_pad    (result_out.max_pad),
        .out_max_charge (result_out.max_charge),
        .out_x_position (result_out.x_position),
        .out_x_valid    (result_out.x_valid),
        .out_y_position (result_out.y_position)
    );

endmodule

FILE: rtl/pcp_ram.sv
module pcp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/pcp_datapath.sv
module pcp_datapath #(
    parameter int MAX_SAMPLES = 512,
    parameter int PAD_COUNT   = 224
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pcp_pkg::cmd_t                   cmd,
    output pcp_pkg::stat_t                  stat,
    input  logic                            cfg_we,
    input  logic [pcp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcp_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pcp_pkg::PAD_W-1:0]       in_pad,
    input  logic [pcp_pkg::VAL_W-1:0]       in_value,
    input  logic [pcp_pkg::TIME_W-1:0]      in_time,
    input  logic                            in_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pcp_pkg::PAD_W-1:0]       out_max_pad,
    output logic [pcp_pkg::VAL_W-1:0]       out_max_charge,
    output logic signed [31:0]              out_x_position,
    output logic                            out_x_valid,
    output logic signed [31:0]              out_y_position
);
    import pcp_pkg::*;

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SV_W = VAL_W + CW;
    localparam int PV_W = PAD_W + VAL_W + CW;
    localparam int NW   = PV_W + 18;
    localparam int R_W  = NW - Q_W;
    localparam logic [CW-1:0]    MAX_CNT  = CW'(MAX_SAMPLES);
    localparam logic [PAD_W:0]   PAD_LAST = (PAD_W + 1)'(PAD_COUNT - 1);

    // Configuration registers.
    logic signed [CFG_W-1:0] x_slope_reg, x_offset_reg, y_slope_reg, y_offset_reg;
    logic [HW_W-1:0]         half_win_reg;

    // Load side.
    logic [CW-1:0]     cnt_reg, n_reg;
    logic [TIME_W-1:0] time_reg;
    logic              in_acc;
    logic              ram_we;
    logic [ENTRY_W-1:0] ram_rdata;

    // Scan side.
    logic [CW-1:0]    rd_idx_reg, rd_pos_reg;
    logic             rd_vld_reg, tail_reg, done_reg;
    logic             issue;
    logic [PAD_W-1:0] rd_pad, a_pad_reg, b_pad_reg;
    logic [VAL_W-1:0] rd_val, b_val_reg;
    logic             mid_eval, eval, has_prev, has_next, counted;

    // Results of the passes.
    logic [PAD_W-1:0] maxp_reg;
    logic [VAL_W-1:0] maxv_reg;
    logic [PAD_W:0]   win_lo, win_hi, hi_sum;
    logic             in_win;
    logic [SV_W-1:0]  sum_v_reg;
    logic [PV_W-1:0]  sum_pv_reg;

    // Divider.
    logic [NW-1:0]      numer;
    logic [SV_W:0]      denom_reg;
    logic [R_W-1:0]     rem_reg, rem_sh;
    logic [Q_W-1:0]     nlow_reg, q_reg;
    logic [Q_CNT_W-1:0] div_cnt_reg;

    // Multiply and final stage.
    logic [Q_W:0]           mean;
    logic signed [57:0]     prod_x_reg;
    logic signed [48:0]     prod_y_reg;
    logic signed [63:0]     x_wide, y_wide, x_round;
    logic                   out_vld_reg;

    assign in_ready = cmd.load;
    assign in_acc   = in_valid && cmd.load;
    assign ram_we   = in_acc && (cnt_reg != MAX_CNT);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_slope_reg  <= X_SLOPE_RST;
            x_offset_reg <= X_OFFSET_RST;
            y_slope_reg  <= Y_SLOPE_RST;
            y_offset_reg <= Y_OFFSET_RST;
            half_win_reg <= HALF_WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_X_SLOPE:  x_slope_reg  <= cfg_data;
                CFG_X_OFFSET: x_offset_reg <= cfg_data;
                CFG_Y_SLOPE:  y_slope_reg  <= cfg_data;
                CFG_Y_OFFSET: y_offset_reg <= cfg_data;
                CFG_HALF_WIN: half_win_reg <= cfg_data[HW_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample counting; a full store drops further samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            n_reg    <= '0;
            time_reg <= '0;
        end
        else if (in_acc)
        begin
            if (in_last)
            begin
                n_reg    <= (cnt_reg != MAX_CNT) ? cnt_reg + 1'b1 : cnt_reg;
                time_reg <= in_time;
                cnt_reg  <= '0;
            end
            else if (cnt_reg != MAX_CNT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    pcp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({in_pad, in_value}),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_pad = ram_rdata[ENTRY_W-1:VAL_W];
    assign rd_val = ram_rdata[VAL_W-1:0];
    assign issue  = cmd.scan_run && (rd_idx_reg != n_reg);

    // Read sequencer: one entry per cycle, then a tail step for the final entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            rd_pos_reg <= '0;
            rd_vld_reg <= 1'b0;
            tail_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (!cmd.scan_run || done_reg)
                rd_idx_reg <= '0;
            else if (issue)
                rd_idx_reg <= rd_idx_reg + 1'b1;
            rd_pos_reg <= rd_idx_reg;
            rd_vld_reg <= issue;
            tail_reg   <= rd_vld_reg && (rd_pos_reg == n_reg - 1'b1);
            done_reg   <= tail_reg;
        end
    end

    // Neighbor window: entry b is judged once its successor arrives or the list ends.
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            a_pad_reg <= b_pad_reg;
            b_pad_reg <= rd_pad;
            b_val_reg <= rd_val;
        end
    end

    assign mid_eval = rd_vld_reg && (rd_pos_reg != '0);
    assign eval     = mid_eval || tail_reg;
    assign has_prev = mid_eval ? (rd_pos_reg > CW'(1)) : (n_reg > CW'(1));
    assign has_next = mid_eval;
    assign counted  = (has_prev && (b_pad_reg == a_pad_reg)) ||
                      (has_next && (b_pad_reg == rd_pad));

    // Window bounds around the maximum pad.
    always_comb
    begin
        hi_sum = {1'b0, maxp_reg} + {{(PAD_W + 1 - HW_W){1'b0}}, half_win_reg};
        win_hi = (hi_sum > PAD_LAST) ? PAD_LAST : hi_sum;
        if ({1'b0, maxp_reg} > {{(PAD_W + 1 - HW_W){1'b0}}, half_win_reg})
            win_lo = {1'b0, maxp_reg} - {{(PAD_W + 1 - HW_W){1'b0}}, half_win_reg};
        else
            win_lo = '0;
        in_win = ({1'b0, b_pad_reg} >= win_lo) && ({1'b0, b_pad_reg} <= win_hi);
    end

    // First pass: largest counted value, strictly greater wins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxp_reg <= '0;
            maxv_reg <= '0;
        end
        else if (cmd.load)
        begin
            maxp_reg <= '0;
            maxv_reg <= '0;
        end
        else if (eval && !cmd.pass_sum && counted && (b_val_reg > maxv_reg))
        begin
            maxp_reg <= b_pad_reg;
            maxv_reg <= b_val_reg;
        end
    end

    // Second pass: window sums.
    always_ff @(posedge clk)
    begin
        if (!cmd.pass_sum)
        begin
            sum_v_reg  <= '0;
            sum_pv_reg <= '0;
        end
        else if (eval && counted && in_win)
        begin
            sum_v_reg  <= sum_v_reg + SV_W'(b_val_reg);
            sum_pv_reg <= sum_pv_reg + PV_W'(b_pad_reg * b_val_reg);
        end
    end

    // Restoring divider: q = (sum_pv*2^17 + sum_v) / (2*sum_v), one bit per cycle.
    assign numer  = {1'b0, sum_pv_reg, 17'd0} + NW'(sum_v_reg);
    assign rem_sh = {rem_reg[R_W-2:0], nlow_reg[Q_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            div_cnt_reg <= Q_CNT_W'(Q_W);
        end
        else if (cmd.div_step && (div_cnt_reg != '0))
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg   <= numer[NW-1:Q_W];
            nlow_reg  <= numer[Q_W-1:0];
            denom_reg <= {sum_v_reg, 1'b0};
            q_reg     <= '0;
        end
        else if (cmd.div_step && (div_cnt_reg != '0))
        begin
            nlow_reg <= {nlow_reg[Q_W-2:0], 1'b0};
            if (rem_sh >= R_W'(denom_reg))
            begin
                rem_reg <= rem_sh - R_W'(denom_reg);
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    // Scaling products.
    assign mean = {1'b0, q_reg} + HALF_Q16;

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_x_reg <= $signed({1'b0, mean}) * x_slope_reg;
            prod_y_reg <= $signed({1'b0, time_reg}) * y_slope_reg;
        end
    end

    // Round x to Q16.16 and add offsets; both are saturated in the output register.
    always_comb
    begin
        x_round = (64'(prod_x_reg) + 64'sd32768) >>> 16;
        x_wide  = x_round + 64'(x_offset_reg);
        y_wide  = 64'(prod_y_reg) + 64'(y_offset_reg);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_max_pad    <= maxp_reg;
            out_max_charge <= maxv_reg;
            out_x_valid    <= (sum_v_reg != '0);
            out_x_position <= (sum_v_reg != '0) ? sat32(x_wide) : 32'sd0;
            out_y_position <= sat32(y_wide);
        end
    end

    assign out_valid      = out_vld_reg;
    assign stat.last_acc  = in_acc && in_last;
    assign stat.scan_done = done_reg;
    assign stat.div_done  = (div_cnt_reg == '0);
    assign stat.out_free  = !out_vld_reg || out_ready;

endmodule

FILE: rtl/pcp_ctrl.sv
module pcp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  pcp_pkg::stat_t stat,
    output pcp_pkg::cmd_t  cmd
);
    import pcp_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (stat.last_acc)  state_next = ST_MAX;
            ST_MAX:  if (stat.scan_done) state_next = ST_SUM;
            ST_SUM:  if (stat.scan_done) state_next = ST_DIV;
            ST_DIV:  if (stat.div_done)  state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  if (stat.out_free)  state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_LOAD: cmd.load = 1'b1;
            ST_MAX:  cmd.scan_run = 1'b1;
            ST_SUM:
            begin
                cmd.scan_run = 1'b1;
                cmd.pass_sum = 1'b1;
                cmd.div_init = stat.scan_done;
            end
            ST_DIV:
            begin
                cmd.pass_sum = 1'b1;
                cmd.div_step = 1'b1;
            end
            ST_MUL:
            begin
                cmd.pass_sum = 1'b1;
                cmd.mult     = 1'b1;
            end
            ST_FIN:
            begin
                cmd.pass_sum = 1'b1;
                cmd.finish   = stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

FILE: rtl/pcp_checker.sv
module pcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_max_pad,
    input logic [31:0] out_x_position,
    input logic        out_x_valid
);

    logic [1:0] pend_reg;
    logic       last_acc, out_acc;

    assign last_acc = in_valid && in_ready && in_last;
    assign out_acc  = out_valid && out_ready;

    // Events closed but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (last_acc && !out_acc)
            pend_reg <= pend_reg + 1'b1;
        else if (out_acc && !last_acc)
            pend_reg <= pend_reg - 1'b1;
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its max pad and x position.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_max_pad) && $stable(out_x_position))
        else $error("result changed while stalled");

    // Every result belongs to a closed event.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a closed event");

    // An empty window reports a zero position.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_x_valid |-> out_x_position == 32'd0)
        else $error("nonzero x position with empty window");

endmodule

bind pad_centroid_position pcp_checker u_pcp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_in.valid),
    .in_ready       (sample_in.ready),
    .in_last        (sample_in.last),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .out_max_pad    (result_out.max_pad),
    .out_x_position (result_out.x_position),
    .out_x_valid    (result_out.x_valid)
);
